// File: src/tamal_pkg.sv
// Package for the two-axis moving-average locator.
// Ring depth, derived widths, reciprocal constant, register map and shared types.
// No dependencies.
package tamal_pkg;

    // Ring depth; everything below is derived from it.
    localparam int DEPTH   = 35;
    localparam int POS_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SMP_W   = 16;
    localparam int SUM_W   = SMP_W + POS_W;
    localparam int HALF    = DEPTH / 2;

    // avg = ((sum + HALF) * RECIP) >> RECIP_SHIFT, exact for all sums below 2^SUM_W
    localparam int RECIP_SHIFT = SUM_W + POS_W;
    localparam int RECIP_W     = RECIP_SHIFT - POS_W + 1;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << RECIP_SHIFT) + 64'(DEPTH) - 64'd1) / 64'(DEPTH);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
    localparam int PROD_W = SUM_W + RECIP_W;

    // Config port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int IDX_W  = 3;

    localparam logic [IDX_W-1:0] REG_X_LOW    = 3'd0;
    localparam logic [IDX_W-1:0] REG_Y_LOW    = 3'd1;
    localparam logic [IDX_W-1:0] REG_X_GAIN   = 3'd2;
    localparam logic [IDX_W-1:0] REG_Y_GAIN   = 3'd3;
    localparam logic [IDX_W-1:0] REG_X_OFFSET = 3'd4;
    localparam logic [IDX_W-1:0] REG_Y_OFFSET = 3'd5;

    localparam logic [15:0]        RST_X_LOW    = 16'd26018;
    localparam logic [15:0]        RST_Y_LOW    = 16'd25887;
    localparam logic [15:0]        RST_X_GAIN   = 16'd23893;
    localparam logic [15:0]        RST_Y_GAIN   = 16'd23893;
    localparam logic signed [15:0] RST_X_OFFSET = 16'sd3;
    localparam logic signed [15:0] RST_Y_OFFSET = 16'sd26;

    typedef logic [SMP_W-1:0]  t_sample;
    typedef logic signed [15:0] t_loc;
    typedef logic [31:0]        t_mag;

    // Stage enables handed to each axis lane
    typedef struct packed {
        logic sum_en;
        logic div_en;
        logic map_en;
        logic sat_en;
        logic sq_en;
    } t_lane_ctl;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_SUM  = 7'b0000010,
        ST_DIV  = 7'b0000100,
        ST_MAP  = 7'b0001000,
        ST_SAT  = 7'b0010000,
        ST_SQ   = 7'b0100000,
        ST_OUT  = 7'b1000000
    } t_state;

endpackage

// File: src/tamal_in_if.sv
// Sample channel: valid/ready handshake carrying one x/y sample pair.
// Depends on tamal_pkg.
interface tamal_in_if;
    import tamal_pkg::*;

    logic    valid;
    logic    ready;
    t_sample x_sample;
    t_sample y_sample;

    modport source (output valid, output x_sample, output y_sample, input ready);
    modport sink   (input valid, input x_sample, input y_sample, output ready);
endinterface

// File: src/tamal_out_if.sv
// Location channel: valid/ready handshake carrying x/y location and magnitude squared.
// Depends on tamal_pkg.
interface tamal_out_if;
    import tamal_pkg::*;

    logic valid;
    logic ready;
    t_loc x_location;
    t_loc y_location;
    t_mag magnitude_squared;

    modport source (output valid, output x_location, output y_location,
                    output magnitude_squared, input ready);
    modport sink   (input valid, input x_location, input y_location,
                    input magnitude_squared, output ready);
endinterface

// File: src/two_axis_moving_average_locator_core.sv
// Channel   Dir  Handshake       Word
// i_smp     in   valid/ready     x_sample, y_sample (16 b unsigned each)
// o_loc     out  valid/ready     x_location, y_location (Q8.8), magnitude_squared (Q16.16)
// apb       in   psel/penable    six 16 b registers at byte address 4*i
//
// Each word steps through accept/ring read, sum update and ring write, divide,
// map, round/saturate, square, output load. One word is in flight at a time.
// The result register holds a finished word while the next word is accepted; the
// last step waits only if that register is still full. Synchronous reset clears the ring
// valid bits, sums, position and output valid and presets config; no clearing pass needed.
// Depends on tamal_pkg, tamal_in_if, tamal_out_if, tamal_lane.
module two_axis_moving_average_locator_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    tamal_in_if.sink                      i_smp,
    tamal_out_if.source                   o_loc,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tamal_pkg::ADDR_W-1:0]  paddr,
    input  logic [tamal_pkg::DATA_W-1:0]  pwdata,
    output logic [tamal_pkg::DATA_W-1:0]  prdata,
    output logic                          pready
);
    import tamal_pkg::*;

    // Config registers
    logic [15:0]        r_x_low, r_y_low, r_x_gain, r_y_gain;
    logic signed [15:0] r_x_offset, r_y_offset;
    logic [IDX_W-1:0]   reg_idx;
    logic               cfg_wr;

    // Sequencer
    t_state             r_state, n_state;
    logic               accept;
    t_lane_ctl          lane_ctl;

    // Ring memory: x in the low half, y in the high half
    logic [2*SMP_W-1:0] r_ring [DEPTH];
    logic [2*SMP_W-1:0] r_rdata;
    logic [DEPTH-1:0]   r_valid;
    logic [POS_W-1:0]   r_pos;
    t_sample            r_xs, r_ys;
    t_sample            x_old, y_old;

    // Output register
    logic               r_out_valid;
    t_loc               r_out_x, r_out_y;
    t_mag               r_out_mag;
    t_loc               x_loc, y_loc;
    t_mag               x_sq, y_sq;
    logic [32:0]        mag_wide;
    logic               out_load;

    assign pready  = 1'b1;
    assign reg_idx = paddr[IDX_W+1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_low    <= RST_X_LOW;
            r_y_low    <= RST_Y_LOW;
            r_x_gain   <= RST_X_GAIN;
            r_y_gain   <= RST_Y_GAIN;
            r_x_offset <= RST_X_OFFSET;
            r_y_offset <= RST_Y_OFFSET;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_X_LOW:    r_x_low    <= pwdata[15:0];
                REG_Y_LOW:    r_y_low    <= pwdata[15:0];
                REG_X_GAIN:   r_x_gain   <= pwdata[15:0];
                REG_Y_GAIN:   r_y_gain   <= pwdata[15:0];
                REG_X_OFFSET: r_x_offset <= pwdata[15:0];
                REG_Y_OFFSET: r_y_offset <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_X_LOW:    prdata = DATA_W'(r_x_low);
            REG_Y_LOW:    prdata = DATA_W'(r_y_low);
            REG_X_GAIN:   prdata = DATA_W'(r_x_gain);
            REG_Y_GAIN:   prdata = DATA_W'(r_y_gain);
            REG_X_OFFSET: prdata = DATA_W'(unsigned'(r_x_offset));
            REG_Y_OFFSET: prdata = DATA_W'(unsigned'(r_y_offset));
            default:      prdata = '0;
        endcase
    end

    // ---- sequencer ----
    assign i_smp.ready = (r_state == ST_IDLE);
    assign accept      = i_smp.valid && (r_state == ST_IDLE);
    assign out_load    = (r_state == ST_OUT) && (!r_out_valid || o_loc.ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (accept)   n_state = ST_SUM;
            ST_SUM:                n_state = ST_DIV;
            ST_DIV:                n_state = ST_MAP;
            ST_MAP:                n_state = ST_SAT;
            ST_SAT:                n_state = ST_SQ;
            ST_SQ:                 n_state = ST_OUT;
            ST_OUT: if (out_load)  n_state = ST_IDLE;
            default:               n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign lane_ctl.sum_en = (r_state == ST_SUM);
    assign lane_ctl.div_en = (r_state == ST_DIV);
    assign lane_ctl.map_en = (r_state == ST_MAP);
    assign lane_ctl.sat_en = (r_state == ST_SAT);
    assign lane_ctl.sq_en  = (r_state == ST_SQ);

    // ---- ring: read on accept, write back in the following ST_SUM state ----
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rdata <= r_ring[r_pos];
            r_xs    <= i_smp.x_sample;
            r_ys    <= i_smp.y_sample;
        end
        if (r_state == ST_SUM) begin
            r_ring[r_pos] <= {r_ys, r_xs};
        end
    end

    // never-written entries read as zero
    assign x_old = r_valid[r_pos] ? r_rdata[SMP_W-1:0]     : '0;
    assign y_old = r_valid[r_pos] ? r_rdata[2*SMP_W-1:SMP_W] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_pos   <= '0;
        end else if (r_state == ST_SUM) begin
            r_valid[r_pos] <= 1'b1;
            r_pos <= (r_pos == POS_W'(DEPTH - 1)) ? '0 : r_pos + POS_W'(1);
        end
    end

    tamal_lane u_x_lane (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (lane_ctl),
        .i_sample (r_xs),
        .i_old    (x_old),
        .i_low    (r_x_low),
        .i_gain   (r_x_gain),
        .i_offset (r_x_offset),
        .o_loc    (x_loc),
        .o_sq     (x_sq)
    );

    tamal_lane u_y_lane (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (lane_ctl),
        .i_sample (r_ys),
        .i_old    (y_old),
        .i_low    (r_y_low),
        .i_gain   (r_y_gain),
        .i_offset (r_y_offset),
        .o_loc    (y_loc),
        .o_sq     (y_sq)
    );

    // peak is 2^31, fits in 32 bits
    assign mag_wide = 33'(x_sq) + 33'(y_sq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_loc.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_x   <= x_loc;
            r_out_y   <= y_loc;
            r_out_mag <= mag_wide[31:0];
        end
    end

    assign o_loc.valid             = r_out_valid;
    assign o_loc.x_location        = r_out_x;
    assign o_loc.y_location        = r_out_y;
    assign o_loc.magnitude_squared = r_out_mag;

endmodule

// File: src/tamal_lane.sv
// One axis: running sum, divide by ring depth, linear map with saturation, square.
// Depends on tamal_pkg; stages are stepped by the top-level sequencer.
module tamal_lane (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tamal_pkg::t_lane_ctl  i_ctl,
    input  tamal_pkg::t_sample    i_sample,
    input  tamal_pkg::t_sample    i_old,
    input  logic [15:0]           i_low,
    input  logic [15:0]           i_gain,
    input  logic signed [15:0]    i_offset,
    output tamal_pkg::t_loc       o_loc,
    output tamal_pkg::t_mag       o_sq
);
    import tamal_pkg::*;

    logic [SUM_W-1:0]       r_sum;
    logic [PROD_W-1:0]      r_prod;
    logic signed [33:0]     r_mul;
    logic signed [15:0]     r_loc;
    logic [31:0]            r_sq;

    logic [SUM_W-1:0]       n_sum;
    logic [SUM_W-1:0]       sum_rnd;
    logic [15:0]            avg;
    logic signed [16:0]     diff;
    logic signed [34:0]     rnd;
    logic signed [18:0]     shifted;
    logic signed [18:0]     loc_wide;
    logic signed [31:0]     sq_full;

    assign n_sum   = r_sum - SUM_W'(i_old) + SUM_W'(i_sample);
    assign sum_rnd = r_sum + SUM_W'(HALF);
    assign avg     = r_prod[RECIP_SHIFT +: 16];
    assign diff    = $signed({1'b0, avg}) - $signed({1'b0, i_low});

    // floor((p + 2^15) / 2^16) is an arithmetic shift after the bias
    assign rnd      = 35'(r_mul) + 35'sd32768;
    assign shifted  = 19'(rnd >>> 16);
    assign loc_wide = shifted + 19'(i_offset);
    assign sq_full  = r_loc * r_loc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_ctl.sum_en) begin
            r_sum <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.div_en) begin
            r_prod <= PROD_W'(sum_rnd) * PROD_W'(RECIP);
        end
        if (i_ctl.map_en) begin
            r_mul <= 34'(diff) * 34'($signed({1'b0, i_gain}));
        end
        if (i_ctl.sat_en) begin
            priority if (loc_wide > 19'sd32767) begin
                r_loc <= 16'sh7fff;
            end else if (loc_wide < -19'sd32768) begin
                r_loc <= 16'sh8000;
            end else begin
                r_loc <= loc_wide[15:0];
            end
        end
        if (i_ctl.sq_en) begin
            r_sq <= 32'(unsigned'(sq_full));
        end
    end

    assign o_loc = r_loc;
    assign o_sq  = r_sq;

endmodule
